// ----- sv/sqvg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqvg_pkg
// Shared types, constants and elaboration-time functions for the sprite quad
// vertex generator: transaction structs, quarter-wave sine table, rounding
// and saturation helpers.
// ----------------------------------------------------------------------------
package sqvg_pkg;

    // field widths
    localparam int POS_W      = 24;
    localparam int TEX_W      = 16;
    localparam int ANGLE_W    = 10;
    localparam int FRAC_BITS  = 8;

    // angle and trig format
    localparam int ANGLE_STEPS = 1 << ANGLE_W;
    localparam int QTR_BITS    = ANGLE_W - 2;
    localparam int SIN_TAB_N   = 1 << QTR_BITS;
    localparam int QX_W        = 14;
    localparam int TRIG_FRAC   = 14;
    localparam int TRIG_ONE    = 1 << TRIG_FRAC;
    localparam int TRIG_HALF   = 1 << (TRIG_FRAC - 1);
    localparam int MAG_W       = TRIG_FRAC + 1;
    localparam int TRIG_W      = TRIG_FRAC + 2;

    // datapath widths
    localparam int DIFF_W  = POS_W + 1;
    localparam int PROD_W  = TRIG_W + DIFF_W;
    localparam int RND_W   = PROD_W - TRIG_FRAC;
    localparam int RX_W    = RND_W + 2;
    localparam int VSUM_W  = RX_W + 2;

    // queues
    localparam int CORNERS     = 4;
    localparam int CORNER_W    = 2;
    localparam int JOBQ_DEPTH  = 2;
    localparam int JOBQ_PTR_W  = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CNT_W  = $clog2(JOBQ_DEPTH + 1);
    localparam int OBUF_DEPTH  = 16;
    localparam int OBUF_PTR_W  = $clog2(OBUF_DEPTH);
    localparam int OBUF_CNT_W  = $clog2(OBUF_DEPTH + 1);
    localparam int JOB_PTR_W   = OBUF_PTR_W - CORNER_W;

    // saturation bounds
    localparam logic signed [VSUM_W-1:0] POS_MAX = VSUM_W'((1 << (POS_W - 1)) - 1);
    localparam logic signed [VSUM_W-1:0] POS_MIN = -VSUM_W'(1 << (POS_W - 1));

    // odd sine polynomial, Q30 coefficients, highest power first
    localparam longint POLY_C9 = 172272;
    localparam longint POLY_C7 = -5026995;
    localparam longint POLY_C5 = 85569306;
    localparam longint POLY_C3 = -693598668;
    localparam longint POLY_C1 = 1686629713;

    typedef enum logic [CORNER_W-1:0] {
        CORNER_TL = 2'd0,
        CORNER_TR = 2'd1,
        CORNER_BR = 2'd2,
        CORNER_BL = 2'd3
    } t_corner;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] size_w;
        logic signed [POS_W-1:0] size_h;
        logic signed [POS_W-1:0] pivot_x;
        logic signed [POS_W-1:0] pivot_y;
        logic [ANGLE_W-1:0]      angle;
        logic [TEX_W-1:0]        u_left;
        logic [TEX_W-1:0]        v_top;
        logic [TEX_W-1:0]        u_right;
        logic [TEX_W-1:0]        v_bottom;
    } t_sprite;

    typedef struct packed {
        logic signed [POS_W-1:0] vert_x;
        logic signed [POS_W-1:0] vert_y;
        logic [TEX_W-1:0]        tex_u;
        logic [TEX_W-1:0]        tex_v;
        logic [CORNER_W-1:0]     corner;
        logic                    last;
    } t_vertex;

    // prepared sprite handed from front to back
    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_v;
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [DIFF_W-1:0] dx_r;
        logic signed [DIFF_W-1:0] dx_l;
        logic signed [DIFF_W-1:0] dy_t;
        logic signed [DIFF_W-1:0] dy_b;
        logic signed [DIFF_W-1:0] org_x;
        logic signed [DIFF_W-1:0] org_y;
        logic [TEX_W-1:0]         u_left;
        logic [TEX_W-1:0]         v_top;
        logic [TEX_W-1:0]         u_right;
        logic [TEX_W-1:0]         v_bottom;
    } t_job;

    typedef logic [MAG_W-1:0] t_sin_tab [0:SIN_TAB_N-1];

    // round to nearest, ties away from zero, by 30 bits
    function automatic longint rnd30(input longint v);
        longint half;
        half = longint'(1) <<< 29;
        if (v >= 0) begin
            return (v + half) >>> 30;
        end
        return -((-v + half) >>> 30);
    endfunction

    // quarter-wave sine magnitude in Q1.14 by Horner evaluation
    function automatic longint qsine(input longint x);
        longint x2;
        longint acc;
        longint r;
        if (x <= 0) begin
            return 0;
        end
        if (x >= TRIG_ONE) begin
            return TRIG_ONE;
        end
        x2  = x * x * 4;
        acc = POLY_C9;
        acc = POLY_C7 + rnd30(acc * x2);
        acc = POLY_C5 + rnd30(acc * x2);
        acc = POLY_C3 + rnd30(acc * x2);
        acc = POLY_C1 + rnd30(acc * x2);
        r   = rnd30(acc * x);
        if (r < 0) begin
            r = 0;
        end
        if (r > TRIG_ONE) begin
            r = TRIG_ONE;
        end
        return r;
    endfunction

    function automatic t_sin_tab build_sin_tab();
        t_sin_tab tab;
        for (int i = 0; i < SIN_TAB_N; i++) begin
            tab[i] = MAG_W'(qsine(longint'(i) <<< (QX_W - QTR_BITS)));
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = build_sin_tab();

    // product rounded from Q.22 to Q.8, ties away from zero
    function automatic logic signed [RND_W-1:0] rnd_trig(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] bias;
        logic signed [PROD_W-1:0] sum;
        bias = p[PROD_W-1] ? PROD_W'(TRIG_HALF - 1) : PROD_W'(TRIG_HALF);
        sum  = p + bias;
        return sum[PROD_W-1:TRIG_FRAC];
    endfunction

    // clamp to the signed position range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [VSUM_W-1:0] v);
        logic signed [VSUM_W-1:0] c;
        c = v;
        if (v > POS_MAX) begin
            c = POS_MAX;
        end
        if (v < POS_MIN) begin
            c = POS_MIN;
        end
        return c[POS_W-1:0];
    endfunction

endpackage

// ----- sv/sqvg_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqvg_front
// Front end: turns an incoming sprite into a prepared job, looking up sine
// and cosine from the quarter-wave table and forming the corner offsets.
// ----------------------------------------------------------------------------
module sqvg_front (
    input  sqvg_pkg::t_sprite i_sprite,
    output sqvg_pkg::t_job    o_job
);

    // signed trig value for a quadrant and a position inside it
    function automatic logic signed [sqvg_pkg::TRIG_W-1:0] trig_phase(
        input logic [1:0]                  q,
        input logic [sqvg_pkg::QTR_BITS-1:0] k
    );
        logic [sqvg_pkg::QTR_BITS-1:0] k_neg;
        logic [sqvg_pkg::MAG_W-1:0]    mag;
        logic signed [sqvg_pkg::TRIG_W-1:0] m;
        k_neg = ~k + sqvg_pkg::QTR_BITS'(1);
        if (q[0]) begin
            if (k == '0) begin
                mag = sqvg_pkg::MAG_W'(sqvg_pkg::TRIG_ONE);
            end else begin
                mag = sqvg_pkg::SIN_TAB[k_neg];
            end
        end else begin
            mag = sqvg_pkg::SIN_TAB[k];
        end
        m = sqvg_pkg::TRIG_W'({1'b0, mag});
        return q[1] ? -m : m;
    endfunction

    logic [1:0]                          quad;
    logic [sqvg_pkg::QTR_BITS-1:0]       pos_in_qtr;
    logic signed [sqvg_pkg::DIFF_W-1:0]  px;
    logic signed [sqvg_pkg::DIFF_W-1:0]  py;
    logic signed [sqvg_pkg::DIFF_W-1:0]  w;
    logic signed [sqvg_pkg::DIFF_W-1:0]  h;
    logic signed [sqvg_pkg::DIFF_W-1:0]  ox;
    logic signed [sqvg_pkg::DIFF_W-1:0]  oy;

    // phase split: quadrant and offset in the quarter
    assign quad       = i_sprite.angle[sqvg_pkg::ANGLE_W-1 -: 2];
    assign pos_in_qtr = i_sprite.angle[sqvg_pkg::QTR_BITS-1:0];

    // sign extension of the geometry
    assign px = {i_sprite.pos_x[sqvg_pkg::POS_W-1],   i_sprite.pos_x};
    assign py = {i_sprite.pos_y[sqvg_pkg::POS_W-1],   i_sprite.pos_y};
    assign w  = {i_sprite.size_w[sqvg_pkg::POS_W-1],  i_sprite.size_w};
    assign h  = {i_sprite.size_h[sqvg_pkg::POS_W-1],  i_sprite.size_h};
    assign ox = {i_sprite.pivot_x[sqvg_pkg::POS_W-1], i_sprite.pivot_x};
    assign oy = {i_sprite.pivot_y[sqvg_pkg::POS_W-1], i_sprite.pivot_y};

    // job record: trig, corner offsets about the pivot, world origin
    always_comb begin
        o_job.sin_v    = trig_phase(quad, pos_in_qtr);
        o_job.cos_v    = trig_phase(quad + 2'd1, pos_in_qtr);
        o_job.dx_r     = w - ox;
        o_job.dx_l     = -ox;
        o_job.dy_t     = -oy;
        o_job.dy_b     = h - oy;
        o_job.org_x    = px + ox;
        o_job.org_y    = py + oy;
        o_job.u_left   = i_sprite.u_left;
        o_job.v_top    = i_sprite.v_top;
        o_job.u_right  = i_sprite.u_right;
        o_job.v_bottom = i_sprite.v_bottom;
    end

endmodule

// ----- sv/sqvg_job_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqvg_job_queue
// Short queue of prepared jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module sqvg_job_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  sqvg_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_rd,
    output logic            o_valid,
    output sqvg_pkg::t_job  o_job
);

    sqvg_pkg::t_job                    r_slot [sqvg_pkg::JOBQ_DEPTH];
    logic [sqvg_pkg::JOBQ_PTR_W-1:0]   r_wr_ptr;
    logic [sqvg_pkg::JOBQ_PTR_W-1:0]   r_rd_ptr;
    logic [sqvg_pkg::JOBQ_CNT_W-1:0]   r_count;
    logic [sqvg_pkg::JOBQ_CNT_W-1:0]   n_count;
    logic                              do_wr;
    logic                              do_rd;

    assign o_full  = (r_count == sqvg_pkg::JOBQ_CNT_W'(sqvg_pkg::JOBQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    // occupancy
    always_comb begin
        n_count = r_count;
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- sv/sqvg_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqvg_back
// Back end: steps through the four corners of a job, one a cycle, through a
// multiply stage and a round-and-sum stage, and writes saturated vertices
// into a result buffer that is read in order.
// ----------------------------------------------------------------------------
module sqvg_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  sqvg_pkg::t_job     i_job,
    output logic               o_job_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output sqvg_pkg::t_vertex  o_vertex
);

    // corner sequencer
    sqvg_pkg::t_corner                  r_step;
    sqvg_pkg::t_corner                  n_step;
    logic [sqvg_pkg::JOB_PTR_W-1:0]     r_wr_base;
    logic                               space_ok;
    logic                               issue;
    logic                               reserve;

    // selected operands
    logic signed [sqvg_pkg::TRIG_W-1:0] sin_v;
    logic signed [sqvg_pkg::TRIG_W-1:0] cos_v;
    logic signed [sqvg_pkg::DIFF_W-1:0] sel_dx;
    logic signed [sqvg_pkg::DIFF_W-1:0] sel_dy;
    logic [sqvg_pkg::TEX_W-1:0]         sel_u;
    logic [sqvg_pkg::TEX_W-1:0]         sel_v;

    // multiply stage
    logic                               r_a_valid;
    sqvg_pkg::t_corner                  r_a_corner;
    logic signed [sqvg_pkg::PROD_W-1:0] r_a_pcx;
    logic signed [sqvg_pkg::PROD_W-1:0] r_a_psy;
    logic signed [sqvg_pkg::PROD_W-1:0] r_a_psx;
    logic signed [sqvg_pkg::PROD_W-1:0] r_a_pcy;
    logic signed [sqvg_pkg::DIFF_W-1:0] r_a_org_x;
    logic signed [sqvg_pkg::DIFF_W-1:0] r_a_org_y;
    logic [sqvg_pkg::TEX_W-1:0]         r_a_u;
    logic [sqvg_pkg::TEX_W-1:0]         r_a_v;
    logic [sqvg_pkg::OBUF_PTR_W-1:0]    r_a_slot;

    // round-and-sum stage
    logic signed [sqvg_pkg::RND_W-1:0]  rnd_cx;
    logic signed [sqvg_pkg::RND_W-1:0]  rnd_sy;
    logic signed [sqvg_pkg::RND_W-1:0]  rnd_sx;
    logic signed [sqvg_pkg::RND_W-1:0]  rnd_cy;
    logic signed [sqvg_pkg::RX_W-1:0]   rot_x;
    logic signed [sqvg_pkg::RX_W-1:0]   rot_y;
    logic signed [sqvg_pkg::RX_W-1:0]   n_b_rx;
    logic signed [sqvg_pkg::RX_W-1:0]   n_b_ry;
    logic                               r_b_valid;
    sqvg_pkg::t_corner                  r_b_corner;
    logic signed [sqvg_pkg::RX_W-1:0]   r_b_rx;
    logic signed [sqvg_pkg::RX_W-1:0]   r_b_ry;
    logic signed [sqvg_pkg::DIFF_W-1:0] r_b_org_x;
    logic signed [sqvg_pkg::DIFF_W-1:0] r_b_org_y;
    logic [sqvg_pkg::TEX_W-1:0]         r_b_u;
    logic [sqvg_pkg::TEX_W-1:0]         r_b_v;
    logic [sqvg_pkg::OBUF_PTR_W-1:0]    r_b_slot;
    logic signed [sqvg_pkg::RX_W-1:0]   r_h_rx1;
    logic signed [sqvg_pkg::RX_W-1:0]   r_h_ry1;
    logic signed [sqvg_pkg::RX_W-1:0]   r_h_rx2;
    logic signed [sqvg_pkg::RX_W-1:0]   r_h_ry2;

    // result buffer
    sqvg_pkg::t_vertex                  r_obuf [sqvg_pkg::OBUF_DEPTH];
    sqvg_pkg::t_vertex                  wr_vertex;
    logic signed [sqvg_pkg::VSUM_W-1:0] sum_x;
    logic signed [sqvg_pkg::VSUM_W-1:0] sum_y;
    logic [sqvg_pkg::OBUF_PTR_W-1:0]    r_rd_ptr;
    logic [sqvg_pkg::OBUF_CNT_W-1:0]    r_used;
    logic [sqvg_pkg::OBUF_CNT_W-1:0]    r_avail;
    logic [sqvg_pkg::OBUF_CNT_W-1:0]    n_used;
    logic [sqvg_pkg::OBUF_CNT_W-1:0]    n_avail;
    logic                               commit;
    logic                               pop_ok;

    // issue control: a job starts only with room for all four vertices
    assign space_ok  = (r_used <= sqvg_pkg::OBUF_CNT_W'(sqvg_pkg::OBUF_DEPTH - sqvg_pkg::CORNERS));
    assign issue     = i_job_valid && ((r_step != sqvg_pkg::CORNER_TR) || space_ok);
    assign reserve   = issue && (r_step == sqvg_pkg::CORNER_TR);
    assign o_job_pop = issue && (r_step == sqvg_pkg::CORNER_TL);

    // next corner: top-right, bottom-right, bottom-left, then top-left
    always_comb begin
        n_step = r_step;
        if (issue) begin
            case (r_step)
                sqvg_pkg::CORNER_TR: n_step = sqvg_pkg::CORNER_BR;
                sqvg_pkg::CORNER_BR: n_step = sqvg_pkg::CORNER_BL;
                sqvg_pkg::CORNER_BL: n_step = sqvg_pkg::CORNER_TL;
                sqvg_pkg::CORNER_TL: n_step = sqvg_pkg::CORNER_TR;
                default:             n_step = sqvg_pkg::CORNER_TR;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= sqvg_pkg::CORNER_TR;
            r_wr_base <= '0;
        end else begin
            r_step <= n_step;
            if (o_job_pop) begin
                r_wr_base <= r_wr_base + 1'b1;
            end
        end
    end

    // corner operand and texture selection
    assign sin_v = i_job.sin_v;
    assign cos_v = i_job.cos_v;

    always_comb begin
        case (r_step)
            sqvg_pkg::CORNER_TR: begin
                sel_dx = i_job.dx_r;
                sel_dy = i_job.dy_t;
                sel_u  = i_job.u_right;
                sel_v  = i_job.v_top;
            end
            sqvg_pkg::CORNER_BR: begin
                sel_dx = i_job.dx_r;
                sel_dy = i_job.dy_b;
                sel_u  = i_job.u_right;
                sel_v  = i_job.v_bottom;
            end
            sqvg_pkg::CORNER_BL: begin
                sel_dx = i_job.dx_l;
                sel_dy = i_job.dy_b;
                sel_u  = i_job.u_left;
                sel_v  = i_job.v_bottom;
            end
            default: begin
                sel_dx = i_job.dx_l;
                sel_dy = i_job.dy_t;
                sel_u  = i_job.u_left;
                sel_v  = i_job.v_top;
            end
        endcase
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_corner <= r_step;
        r_a_pcx    <= sqvg_pkg::PROD_W'(cos_v) * sqvg_pkg::PROD_W'(sel_dx);
        r_a_psy    <= sqvg_pkg::PROD_W'(sin_v) * sqvg_pkg::PROD_W'(sel_dy);
        r_a_psx    <= sqvg_pkg::PROD_W'(sin_v) * sqvg_pkg::PROD_W'(sel_dx);
        r_a_pcy    <= sqvg_pkg::PROD_W'(cos_v) * sqvg_pkg::PROD_W'(sel_dy);
        r_a_org_x  <= i_job.org_x;
        r_a_org_y  <= i_job.org_y;
        r_a_u      <= sel_u;
        r_a_v      <= sel_v;
        r_a_slot   <= {r_wr_base, sqvg_pkg::CORNER_W'(r_step)};
    end

    // rounding and rotation sums; top-left closes the parallelogram
    always_comb begin
        rnd_cx = sqvg_pkg::rnd_trig(r_a_pcx);
        rnd_sy = sqvg_pkg::rnd_trig(r_a_psy);
        rnd_sx = sqvg_pkg::rnd_trig(r_a_psx);
        rnd_cy = sqvg_pkg::rnd_trig(r_a_pcy);
        rot_x  = sqvg_pkg::RX_W'(rnd_cx) - sqvg_pkg::RX_W'(rnd_sy);
        rot_y  = sqvg_pkg::RX_W'(rnd_sx) + sqvg_pkg::RX_W'(rnd_cy);
        if (r_a_corner == sqvg_pkg::CORNER_TL) begin
            n_b_rx = r_h_rx1 + r_b_rx - r_h_rx2;
            n_b_ry = r_h_ry1 + r_b_ry - r_h_ry2;
        end else begin
            n_b_rx = rot_x;
            n_b_ry = rot_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_corner <= r_a_corner;
        r_b_rx     <= n_b_rx;
        r_b_ry     <= n_b_ry;
        r_b_org_x  <= r_a_org_x;
        r_b_org_y  <= r_a_org_y;
        r_b_u      <= r_a_u;
        r_b_v      <= r_a_v;
        r_b_slot   <= r_a_slot;
        if (r_a_corner == sqvg_pkg::CORNER_TR) begin
            r_h_rx1 <= rot_x;
            r_h_ry1 <= rot_y;
        end
        if (r_a_corner == sqvg_pkg::CORNER_BR) begin
            r_h_rx2 <= rot_x;
            r_h_ry2 <= rot_y;
        end
    end

    // move to the world origin and saturate
    always_comb begin
        sum_x            = sqvg_pkg::VSUM_W'(r_b_rx) + sqvg_pkg::VSUM_W'(r_b_org_x);
        sum_y            = sqvg_pkg::VSUM_W'(r_b_ry) + sqvg_pkg::VSUM_W'(r_b_org_y);
        wr_vertex.vert_x = sqvg_pkg::sat_pos(sum_x);
        wr_vertex.vert_y = sqvg_pkg::sat_pos(sum_y);
        wr_vertex.tex_u  = r_b_u;
        wr_vertex.tex_v  = r_b_v;
        wr_vertex.corner = sqvg_pkg::CORNER_W'(r_b_corner);
        wr_vertex.last   = (r_b_corner == sqvg_pkg::CORNER_BL);
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_obuf[r_b_slot] <= wr_vertex;
        end
    end

    // buffer accounting: slots reserved at job start, published with top-left
    assign commit   = r_b_valid && (r_b_corner == sqvg_pkg::CORNER_TL);
    assign o_empty  = (r_avail == '0);
    assign pop_ok   = i_pop && !o_empty;
    assign o_vertex = r_obuf[r_rd_ptr];

    always_comb begin
        n_used  = r_used;
        n_avail = r_avail;
        if (reserve) begin
            n_used = n_used + sqvg_pkg::OBUF_CNT_W'(sqvg_pkg::CORNERS);
        end
        if (commit) begin
            n_avail = n_avail + sqvg_pkg::OBUF_CNT_W'(sqvg_pkg::CORNERS);
        end
        if (pop_ok) begin
            n_used  = n_used - 1'b1;
            n_avail = n_avail - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_avail  <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_used  <= n_used;
            r_avail <= n_avail;
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // published vertices never exceed reserved slots
    a_avail_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_avail <= r_used)
        else $error("result buffer publishes more than it reserved");

    // reservations stay within the buffer
    a_used_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= sqvg_pkg::OBUF_CNT_W'(sqvg_pkg::OBUF_DEPTH))
        else $error("result buffer over-reserved");

    // a job stays at the queue head until its last corner is issued
    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != sqvg_pkg::CORNER_TR) |-> i_job_valid)
        else $error("job left the queue mid-sequence");

    // top-left is derived right after bottom-left of the same job
    a_tl_after_bl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && (r_b_corner == sqvg_pkg::CORNER_TL)) |->
            $past(r_b_valid && (r_b_corner == sqvg_pkg::CORNER_BL)))
        else $error("top-left corner without preceding bottom-left");

endmodule

// ----- sv/sprite_quad_vertex_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_quad_vertex_generator
// Turns one sprite transaction into four rotated, saturated quad vertices
// (top-left, top-right, bottom-right, bottom-left) with texture coordinates.
// ----------------------------------------------------------------------------
// A sprite is taken on push while full is low and yields four vertex
// transactions, read with pop while empty is low, corner 3 marked by last.
// The back end works out one corner a cycle once a sprite has started,
// through a single set of four multipliers, and starts the next sprite after
// the last corner is issued; one vertex per cycle is read while empty is low.
// A sprite's vertices become readable together, when its top-left corner is
// written. A two-entry job queue lets the input side keep accepting while the
// back end is busy, and a sixteen-vertex result buffer lets the back end run
// ahead of a stalled reader.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  sqvg_pkg::t_sprite  i_sprite,
    output logic               empty,
    input  logic               pop,
    output sqvg_pkg::t_vertex  o_vertex
);

    sqvg_pkg::t_job  front_job;
    sqvg_pkg::t_job  head_job;
    logic            head_valid;
    logic            head_pop;

    // sprite preparation
    sqvg_front u_front (
        .i_sprite (i_sprite),
        .o_job    (front_job)
    );

    // decoupling queue
    sqvg_job_queue u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_rd    (head_pop),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    // corner generation and result buffer
    sqvg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (head_valid),
        .i_job       (head_job),
        .o_job_pop   (head_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_vertex    (o_vertex)
    );

endmodule
